// ===== hw/rtl/imu_frame_sync_parser_top_macros.svh =====
// Assertion macros shared by the checker of the IMU frame sync parser.
`ifndef IMU_FRAME_SYNC_PARSER_TOP_MACROS_SVH
`define IMU_FRAME_SYNC_PARSER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("imu frame sync parser: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define FSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("imu frame sync parser: assertion failed");

`endif

// ===== hw/rtl/imu_fsp_pkg.sv =====
// Types, constants and helpers shared by the IMU frame sync parser modules.
package imu_fsp_pkg;

  localparam int unsigned FrameBytes = 11;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CntW       = 16;
  localparam int unsigned ValW       = 16;
  localparam int unsigned TdataW     = 88;
  localparam int unsigned TuserW     = 2;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // Fixed byte positions inside a frame.
  localparam int unsigned PosType = 1;
  localparam int unsigned PosX    = 2;
  localparam int unsigned PosY    = 4;
  localparam int unsigned PosZ    = 6;

  localparam logic [ByteW-1:0] HeaderByte = 8'h55;
  localparam logic [ByteW-1:0] TypeAccel  = 8'h51;
  localparam logic [ByteW-1:0] TypeGyro   = 8'h52;
  localparam logic [ByteW-1:0] TypeAngle  = 8'h53;

  typedef enum logic [1:0] {
    ClsAccel = 2'd0,
    ClsGyro  = 2'd1,
    ClsAngle = 2'd2,
    ClsOther = 2'd3
  } frame_class_e;

  typedef enum logic [1:0] {
    StLoad = 2'b01,
    StScan = 2'b10
  } back_state_e;

  // Queue entry: the received byte and whether it is a frame header.
  typedef struct packed {
    logic             is_header;
    logic [ByteW-1:0] data;
  } rx_entry_t;

  function automatic frame_class_e classify(input logic [ByteW-1:0] type_code);
    frame_class_e cls;
    case (type_code)
      TypeAccel: cls = ClsAccel;
      TypeGyro:  cls = ClsGyro;
      TypeAngle: cls = ClsAngle;
      default:   cls = ClsOther;
    endcase
    return cls;
  endfunction

endpackage

// ===== hw/rtl/imu_fsp_front.sv =====
// Front end: accepts received bytes, tags headers and queues them for the back end.
module imu_fsp_front import imu_fsp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [ByteW-1:0] s_axis_tdata_i,   // rx_byte
  output logic             q_valid_o,
  output rx_entry_t        q_entry_o,
  input  logic             q_pop_i
);

  rx_entry_t        mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             push, pop;
  rx_entry_t        push_entry;

  assign s_axis_tready_o = (cnt_q != QCntW'(QueueDepth));
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign q_valid_o       = (cnt_q != '0);
  assign pop             = q_pop_i && q_valid_o;
  assign q_entry_o       = mem_q[rd_ptr_q];

  always_comb begin
    push_entry.data      = s_axis_tdata_i;
    push_entry.is_header = (s_axis_tdata_i == HeaderByte);
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + QPtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + QPtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry;
    end
  end

endmodule

// ===== hw/rtl/imu_fsp_back.sv =====
// Back end: frame window, header scan, checksum check and output register.
module imu_fsp_back import imu_fsp_pkg::*; #(
  parameter int unsigned FRAME_BYTES = FrameBytes
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  rx_entry_t         q_entry_i,
  output logic              q_pop_o,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [TdataW-1:0] m_axis_tdata_o,  // type_byte, value_x, value_y, value_z,
                                             // checksum_errors, sync_drops
  output logic [TuserW-1:0] m_axis_tuser_o   // frame_class
);

  localparam int unsigned FillW  = $clog2(FRAME_BYTES + 1);
  localparam int unsigned IdxW   = $clog2(FRAME_BYTES);
  localparam int unsigned ChkPos = FRAME_BYTES - 1;

  logic [ByteW-1:0]  win_q [FRAME_BYTES];
  logic [ByteW-1:0]  win_d [FRAME_BYTES];
  logic              hdr_q [FRAME_BYTES];
  logic              hdr_d [FRAME_BYTES];
  logic [FillW-1:0]  fill_q, fill_d;
  logic [ByteW-1:0]  sum_q, sum_d;
  logic [CntW-1:0]   err_q, err_d;
  logic [CntW-1:0]   drop_q, drop_d;
  back_state_e       state_q, state_d;
  logic              out_valid_q, out_valid_d;
  logic [TdataW-1:0] out_data_q;
  logic [TuserW-1:0] out_user_q;
  logic              out_load;
  logic              out_free;
  logic [ByteW-1:0]  head_sum;

  assign out_free = !out_valid_q || m_axis_tready_i;
  // sum_q covers every held byte; removing the checksum byte leaves bytes 0..9.
  assign head_sum = sum_q - win_q[ChkPos];

  always_comb begin
    win_d       = win_q;
    hdr_d       = hdr_q;
    fill_d      = fill_q;
    sum_d       = sum_q;
    err_d       = err_q;
    drop_d      = drop_q;
    state_d     = state_q;
    q_pop_o     = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      StLoad: begin
        if (q_valid_i) begin
          q_pop_o                     = 1'b1;
          win_d[fill_q[IdxW-1:0]]     = q_entry_i.data;
          hdr_d[fill_q[IdxW-1:0]]     = q_entry_i.is_header;
          fill_d                      = fill_q + FillW'(1);
          sum_d                       = sum_q + q_entry_i.data;
          state_d                     = StScan;
        end
      end
      StScan: begin
        if (fill_q < FillW'(2)) begin
          state_d = StLoad;
        end else if (!hdr_q[0] || (fill_q == FillW'(FRAME_BYTES) &&
                                   head_sum != win_q[ChkPos])) begin
          // Drop the front byte: either not a header, or a header whose frame failed.
          for (int unsigned i = 0; i < FRAME_BYTES - 1; i++) begin
            win_d[i] = win_q[i+1];
            hdr_d[i] = hdr_q[i+1];
          end
          fill_d = fill_q - FillW'(1);
          sum_d  = sum_q - win_q[0];
          if (!hdr_q[0]) begin
            if (drop_q != '1) begin
              drop_d = drop_q + CntW'(1);
            end
          end else if (err_q != '1) begin
            err_d = err_q + CntW'(1);
          end
        end else if (fill_q != FillW'(FRAME_BYTES)) begin
          state_d = StLoad;
        end else if (out_free) begin
          out_load = 1'b1;
          fill_d   = '0;
          sum_d    = '0;
          state_d  = StLoad;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      sum_q       <= '0;
      err_q       <= '0;
      drop_q      <= '0;
      state_q     <= StLoad;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      err_q       <= err_d;
      drop_q      <= drop_d;
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    hdr_q <= hdr_d;
    if (out_load) begin
      out_user_q <= TuserW'(classify(win_q[PosType]));
      out_data_q <= {drop_d, err_d,
                     win_q[PosZ+1], win_q[PosZ],
                     win_q[PosY+1], win_q[PosY],
                     win_q[PosX+1], win_q[PosX],
                     win_q[PosType]};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

// ===== hw/rtl/imu_frame_sync_parser_top.sv =====
// A completing byte passes the queue, window load and scan; its frame is registered at the
// output if the scan is clear. The back end loads bytes one at a time, scanning one step per
// cycle unless a frame waits on the output; a checksum failure rescans up to ten held bytes.
// A 4-entry byte queue lets input be taken while the back end scans or the output stalls.
// Reset (rst_ni low, asynchronous) empties the queue and window and clears both counters.
module imu_frame_sync_parser_top import imu_fsp_pkg::*; #(
  parameter int unsigned FRAME_BYTES = FrameBytes
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [ByteW-1:0]  s_axis_tdata_i,   // rx_byte
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [TdataW-1:0] m_axis_tdata_o,   // type_byte, value_x, value_y, value_z,
                                              // checksum_errors, sync_drops
  output logic [TuserW-1:0] m_axis_tuser_o    // frame_class
);

  logic      q_valid;
  rx_entry_t q_entry;
  logic      q_pop;

  imu_fsp_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .q_valid_o       (q_valid),
    .q_entry_o       (q_entry),
    .q_pop_i         (q_pop)
  );

  imu_fsp_back #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_entry_i       (q_entry),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

// ===== hw/rtl/imu_fsp_checker.sv =====
// Port-level checker for the IMU frame sync parser, bound to the top level.
`include "imu_frame_sync_parser_top_macros.svh"

module imu_fsp_checker import imu_fsp_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid_i,
  input logic              s_axis_tready_o,
  input logic [ByteW-1:0]  s_axis_tdata_i,
  input logic              m_axis_tvalid_o,
  input logic              m_axis_tready_i,
  input logic [TdataW-1:0] m_axis_tdata_o,
  input logic [TuserW-1:0] m_axis_tuser_o
);

  logic                     out_stall;
  logic [TdataW+TuserW-1:0] out_item;
  logic [ByteW-1:0]         out_type;
  logic                     cls_ok;

  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_item  = {m_axis_tuser_o, m_axis_tdata_o};
  assign out_type  = m_axis_tdata_o[ByteW-1:0];
  assign cls_ok    = ((m_axis_tuser_o == ClsAccel) == (out_type == TypeAccel)) &&
                     ((m_axis_tuser_o == ClsGyro)  == (out_type == TypeGyro)) &&
                     ((m_axis_tuser_o == ClsAngle) == (out_type == TypeAngle));

  // A stalled result item keeps its contents.
  `FSP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid_o && $stable(out_item))

  // The class must agree with the type byte carried in the same item.
  `FSP_ASSERT_NOW(a_class_match, clk_i, rst_ni, m_axis_tvalid_o, cls_ok)

  // A valid result item carries only known bits.
  `FSP_ASSERT_NOW(a_out_known, clk_i, rst_ni, m_axis_tvalid_o, !$isunknown(out_item))

endmodule

bind imu_frame_sync_parser_top imu_fsp_checker u_checker (.*);

// ===== test/tb.sv =====
// Testbench for the IMU frame sync parser: random byte streams in, parsed frames checked.
`timescale 1ns / 100ps

typedef struct {
  imu_fsp_pkg::frame_class_e cls;
  logic [7:0]                type_code;
  logic [15:0]               x;
  logic [15:0]               y;
  logic [15:0]               z;
  logic [15:0]               csum_errs;
  logic [15:0]               drops;
} imu_frame_t;

class frame_scoreboard;
  logic [7:0]  held [imu_fsp_pkg::FrameBytes];
  int unsigned held_count = 0;
  logic [15:0] csum_errs = '0;
  logic [15:0] drops = '0;
  imu_frame_t  frames_due [$];
  int unsigned errors = 0;

  function void log_error(string msg);
    errors++;
    if (errors <= 10) $display("%0t ns: %s", $time, msg);
  endfunction

  function void drop_oldest();
    for (int unsigned i = 0; i + 1 < held_count; i++) held[i] = held[i + 1];
    held_count--;
  endfunction

  // Appends one accepted byte and runs the header scan until it has to wait.
  function void push_rx_byte(logic [7:0] rx);
    imu_frame_t f;
    logic [7:0] sum;
    bit         scanning;
    held[held_count] = rx;
    held_count++;
    scanning = 1'b1;
    while (scanning && held_count >= 2) begin
      if (held[0] != imu_fsp_pkg::HeaderByte) begin
        drop_oldest();
        if (drops != 16'hFFFF) drops++;
      end else if (held_count < imu_fsp_pkg::FrameBytes) begin
        scanning = 1'b0;
      end else begin
        sum = '0;
        for (int i = 0; i < imu_fsp_pkg::FrameBytes - 1; i++) sum += held[i];
        if (sum != held[imu_fsp_pkg::FrameBytes - 1]) begin
          if (csum_errs != 16'hFFFF) csum_errs++;
          drop_oldest();
        end else begin
          f.type_code = held[imu_fsp_pkg::PosType];
          case (f.type_code)
            imu_fsp_pkg::TypeAccel: f.cls = imu_fsp_pkg::ClsAccel;
            imu_fsp_pkg::TypeGyro:  f.cls = imu_fsp_pkg::ClsGyro;
            imu_fsp_pkg::TypeAngle: f.cls = imu_fsp_pkg::ClsAngle;
            default:                f.cls = imu_fsp_pkg::ClsOther;
          endcase
          f.x = {held[imu_fsp_pkg::PosX + 1], held[imu_fsp_pkg::PosX]};
          f.y = {held[imu_fsp_pkg::PosY + 1], held[imu_fsp_pkg::PosY]};
          f.z = {held[imu_fsp_pkg::PosZ + 1], held[imu_fsp_pkg::PosZ]};
          f.csum_errs = csum_errs;
          f.drops = drops;
          frames_due.push_back(f);
          held_count = 0;
          scanning = 1'b0;
        end
      end
    end
  endfunction

  function void compare(string field, logic [15:0] want_v, logic [15:0] got_v);
    if (got_v !== want_v)
      log_error($sformatf("%s expected %0h, got %0h", field, want_v, got_v));
  endfunction

  function void check_frame(logic [imu_fsp_pkg::TuserW-1:0] user,
                            logic [imu_fsp_pkg::TdataW-1:0] data);
    imu_frame_t want;
    if (frames_due.size() == 0) begin
      log_error($sformatf("frame of type %02h arrived with none predicted", data[7:0]));
      return;
    end
    want = frames_due.pop_front();
    compare("frame_class", 16'(want.cls), 16'(user));
    compare("type_byte", 16'(want.type_code), 16'(data[7:0]));
    compare("value_x", want.x, data[23:8]);
    compare("value_y", want.y, data[39:24]);
    compare("value_z", want.z, data[55:40]);
    compare("checksum_errors", want.csum_errs, data[71:56]);
    compare("sync_drops", want.drops, data[87:72]);
  endfunction
endclass

module tb;
  import imu_fsp_pkg::*;

  localparam int unsigned CycleLimit  = 200_000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned RandomBytes = 1090;
  localparam int unsigned DrainCycles = 80;

  typedef enum logic [1:0] {
    RxFree,
    RxMostly,
    RxSparse,
    RxPeriodic
  } rx_mode_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [ByteW-1:0]  s_axis_tdata_i = '0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [TdataW-1:0] m_axis_tdata_o;
  logic [TuserW-1:0] m_axis_tuser_o;

  frame_scoreboard sb;
  bit              gaps_on = 1'b1;
  int unsigned     burst_left = 0;
  int unsigned     bytes_sent = 0;
  int unsigned     hold_requests = 0;
  int unsigned     holds_served = 0;
  int unsigned     hold_left = 0;
  int unsigned     rx_phase_left = 0;
  int unsigned     cycle_count = 0;
  rx_mode_e        rx_mode = RxFree;

  imu_frame_sync_parser_top dut (.*);

  always #2 clk_i = ~clk_i;

  // Header bytes are favored so that broken frames hide headers for the rescan to find.
  function automatic logic [7:0] payload();
    return ($urandom_range(0, 7) == 0) ? HeaderByte : 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_type();
    case ($urandom_range(0, 6))
      0, 1:    return TypeAccel;
      2, 3:    return TypeGyro;
      4, 5:    return TypeAngle;
      default: return payload();
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] rx);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= rx;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.push_rx_byte(rx);
    bytes_sent++;
  endtask

  // A nonzero skew spoils the checksum byte.
  task automatic send_frame(input logic [7:0] type_code, input logic [15:0] x, y, z,
                            input logic [7:0] pad_lo, pad_hi, skew);
    logic [7:0] frame [FrameBytes];
    logic [7:0] sum;
    frame = '{HeaderByte, type_code, x[7:0], x[15:8], y[7:0], y[15:8], z[7:0], z[15:8],
              pad_lo, pad_hi, 8'h00};
    sum = '0;
    for (int i = 0; i < FrameBytes - 1; i++) sum += frame[i];
    frame[FrameBytes - 1] = sum + skew;
    for (int i = 0; i < FrameBytes; i++) send_byte(frame[i]);
  endtask

  task automatic send_random_frame(input logic [7:0] skew);
    send_frame(pick_type(), {payload(), payload()}, {payload(), payload()},
               {payload(), payload()}, payload(), payload(), skew);
  endtask

  // The receiver picks a stall mode per phase and can be told to hold off entirely.
  always @(posedge clk_i) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left = HoldCycles;
    end
    if (rx_phase_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_phase_left = $urandom_range(40, 300);
    end
    rx_phase_left--;
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      case (rx_mode)
        RxFree:   m_axis_tready_i <= 1'b1;
        RxMostly: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
        RxSparse: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
        default:  m_axis_tready_i <= (rx_phase_left % 7 < 3);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sb.check_frame(m_axis_tuser_o, m_axis_tdata_o);
    end
  end

  initial begin
    int unsigned target;
    int unsigned pick;
    sb = new;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A lone non-header byte waits until a second byte pushes it out.
    send_byte(8'hFF);
    send_byte(8'h00);
    send_frame(TypeAccel, 16'h8000, 16'h7FFF, 16'hFFFF, 8'hFF, 8'h00, 8'h00);
    // Unknown type with a bad checksum; the rescan meets the embedded headers.
    send_frame(8'h00, 16'h0000, 16'h0055, 16'h5500, 8'h55, 8'hFF, 8'h01);

    target = bytes_sent + RandomBytes;
    while (bytes_sent < target) begin
      if (hold_requests == 0 && bytes_sent + 700 >= target) hold_requests++;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_random_frame(8'h00);
      end else if (pick < 82) begin
        send_random_frame(8'($urandom_range(1, 255)));
      end else if (pick < 92) begin
        // Header followed by a frame that never completes.
        send_byte(HeaderByte);
        repeat ($urandom_range(1, 9)) send_byte(payload());
      end else begin
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
      end
    end

    // Close with back-to-back bytes: a run of non-headers, then complete frames.
    gaps_on = 1'b0;
    repeat (FrameBytes + 1) send_byte(8'h00);
    send_frame(TypeAngle, 16'h1234, 16'hEDCB, 16'h0000, 8'h00, 8'hFF, 8'h00);
    send_random_frame(8'h00);
    s_axis_tvalid_i <= 1'b0;

    while (sb.frames_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.frames_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
